FILE: hdl/vca_pkg.sv
package vca_pkg;

  localparam int unsigned NumVoices = 8;
  localparam int unsigned IdxW      = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumVoices - 1);

  localparam int unsigned EntW  = 16;
  localparam int unsigned SubW  = 4;
  localparam int unsigned LenW  = 24;
  localparam int unsigned NowW  = 31;
  localparam int unsigned EndW  = 32;
  localparam int unsigned LifeW = EndW + 1;

  localparam logic signed [LifeW-1:0] LifeCeiling = 33'sh0_7fff_ffff;
  localparam logic [SubW-1:0] SubAny  = 4'hf;
  localparam logic [SubW-1:0] SubNone = 4'h0;

  typedef enum logic [1:0] {
    ActAlloc = 2'd0,
    ActStop  = 2'd1,
    ActClear = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StScan  = 2'd1,
    StDrain = 2'd2,
    StWrite = 2'd3
  } state_e;

  typedef struct packed {
    logic [EntW-1:0] owner;
    logic [SubW-1:0] sub;
    logic [EndW-1:0] end_time;
    logic            active;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } ram_wr_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] index;
    logic       stole;
  } result_t;

endpackage

FILE: hdl/vca_ram.sv
module vca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/vca_ctrl.sv
module vca_ctrl
  import vca_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       action_i,
  input  logic [EntW-1:0]  entity_i,
  input  logic [SubW-1:0]  sub_i,
  input  logic [LenW-1:0]  len_i,
  input  logic [NowW-1:0]  now_i,
  input  logic [EntW-1:0]  viewer_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  output logic [IdxW-1:0]  ram_raddr_o,
  input  entry_t           ram_rdata_i,
  output ram_wr_t          ram_wr_o
);

  state_e state_q, state_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            proc_vld_q, proc_vld_d;
  logic [IdxW-1:0] proc_idx_q, proc_idx_d;
  logic            found_q, found_d;
  logic            pick_vld_q, pick_vld_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic            pick_act_q, pick_act_d;
  logic signed [LifeW-1:0] best_q, best_d;
  logic [NumVoices-1:0] valid_q, valid_d;

  action_e         act_q;
  logic [EntW-1:0] ent_q;
  logic [SubW-1:0] sub_q;
  logic [LenW-1:0] len_q;
  logic [NowW-1:0] now_q;

  entry_t                  ent_rd;
  logic                    own_match;
  logic                    stop_match;
  logic                    protect;
  logic signed [LifeW-1:0] life;
  logic [IdxW+2:0]         pick_ext;
  logic [EndW-1:0]         new_end;
  logic                    accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    ent_rd     = valid_q[proc_idx_q] ? ram_rdata_i : '0;
    own_match  = (sub_q != SubNone) && (ent_rd.owner == ent_q) &&
                 ((ent_rd.sub == sub_q) || (sub_q == SubAny));
    stop_match = (ent_rd.owner == ent_q) && (ent_rd.sub == sub_q);
    protect    = (ent_rd.owner == viewer_i) && (ent_q != viewer_i) && ent_rd.active;
    life       = $signed({1'b0, ent_rd.end_time}) - $signed({2'b00, now_q});
    pick_ext   = {3'b000, pick_q};
    new_end    = {1'b0, now_q} + {{(EndW-LenW){1'b0}}, len_q};
  end

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    proc_vld_d  = 1'b0;
    proc_idx_d  = proc_idx_q;
    found_d     = found_q;
    pick_vld_d  = pick_vld_q;
    pick_d      = pick_q;
    pick_act_d  = pick_act_q;
    best_d      = best_q;
    valid_d     = valid_q;
    ram_raddr_o = rd_idx_q;
    ram_wr_o    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (proc_vld_q && !found_q) begin
      case (act_q)
        ActAlloc: begin
          if (own_match) begin
            found_d    = 1'b1;
            pick_vld_d = 1'b1;
            pick_d     = proc_idx_q;
            pick_act_d = ent_rd.active;
          end else if (!protect && (life < best_q)) begin
            best_d     = life;
            pick_vld_d = 1'b1;
            pick_d     = proc_idx_q;
            pick_act_d = ent_rd.active;
          end
        end
        ActStop: begin
          if (stop_match) begin
            found_d    = 1'b1;
            pick_vld_d = 1'b1;
            pick_d     = proc_idx_q;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      StIdle: begin
        rd_idx_d   = '0;
        found_d    = 1'b0;
        pick_vld_d = 1'b0;
        pick_d     = '0;
        pick_act_d = 1'b0;
        best_d     = LifeCeiling;
        if (in_valid_i) begin
          if ((action_i == ActAlloc) || (action_i == ActStop)) begin
            state_d = StScan;
          end else begin
            state_d = StWrite;
          end
        end
      end
      StScan: begin
        proc_vld_d = 1'b1;
        proc_idx_d = rd_idx_q;
        if (rd_idx_q == LastIdx) begin
          state_d = StDrain;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StWrite;
      end
      StWrite: begin
        res_valid_o = 1'b1;
        case (act_q)
          ActAlloc: begin
            if (pick_vld_q) begin
              res_o.granted = 1'b1;
              res_o.index   = pick_ext[2:0];
              res_o.stole   = pick_act_q;
            end
          end
          ActStop: begin
            if (found_q) begin
              res_o.granted = 1'b1;
              res_o.index   = pick_ext[2:0];
            end
          end
          default: begin
          end
        endcase
        if (res_ready_i) begin
          state_d = StIdle;
          case (act_q)
            ActAlloc: begin
              if (pick_vld_q) begin
                ram_wr_o.we                = 1'b1;
                ram_wr_o.addr              = pick_q;
                ram_wr_o.data.owner        = ent_q;
                ram_wr_o.data.sub          = sub_q;
                ram_wr_o.data.end_time     = new_end;
                ram_wr_o.data.active       = 1'b1;
                valid_d[pick_q]            = 1'b1;
              end
            end
            ActStop: begin
              if (found_q) begin
                ram_wr_o.we                = 1'b1;
                ram_wr_o.addr              = pick_q;
                ram_wr_o.data.owner        = ent_q;
                ram_wr_o.data.sub          = sub_q;
                ram_wr_o.data.end_time     = '0;
                ram_wr_o.data.active       = 1'b0;
                valid_d[pick_q]            = 1'b1;
              end
            end
            ActClear: begin
              valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
      found_q    <= 1'b0;
      pick_vld_q <= 1'b0;
      pick_q     <= '0;
      pick_act_q <= 1'b0;
      best_q     <= LifeCeiling;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      proc_vld_q <= proc_vld_d;
      proc_idx_q <= proc_idx_d;
      found_q    <= found_d;
      pick_vld_q <= pick_vld_d;
      pick_q     <= pick_d;
      pick_act_q <= pick_act_d;
      best_q     <= best_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(action_i);
      ent_q <= entity_i;
      sub_q <= sub_i;
      len_q <= len_i;
      now_q <= now_i;
    end
  end

endmodule

FILE: hdl/voice_channel_allocator.sv
// Voice channel allocator: NumVoices entries in one RAM, scanned one per cycle.
// Allocate and stop pass through the scan, drain and write states; clear and
// unused codes go straight to the write state. One item in flight; the next item
// is taken the cycle after the result is handed to the output register.
// Reset (async, active low) empties the table via per-entry valid bits.
module voice_channel_allocator
  import vca_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [EntW-1:0]         entity_i,
  input  logic signed [SubW-1:0]  sub_channel_i,
  input  logic [LenW-1:0]         sound_length_i,
  input  logic [NowW-1:0]         now_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    granted_o,
  output logic [2:0]              channel_index_o,
  output logic                    stole_active_o,
  input  logic                    cfg_we_i,
  input  logic [EntW-1:0]         cfg_wdata_i
);

  logic [EntW-1:0] viewer_q;
  logic            out_valid_q;
  result_t         res_q;
  logic            res_valid;
  logic            res_ready;
  result_t         res;
  logic [IdxW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  ram_wr_t         ram_wr;

  assign res_ready = !out_valid_q || out_ready_i;

  vca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .entity_i    (entity_i),
    .sub_i       (sub_channel_i),
    .len_i       (sound_length_i),
    .now_i       (now_i),
    .viewer_i    (viewer_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (entry_t'(ram_rdata)),
    .ram_wr_o    (ram_wr)
  );

  vca_ram #(
    .Width (EntryW),
    .Depth (NumVoices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        viewer_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = res_q.granted;
  assign channel_index_o = res_q.index;
  assign stole_active_o  = res_q.stole;

endmodule
